>>> src/imudf_pkg.sv
// ----------------------------------------------------------------------------
// imudf_pkg
// Types, codes and widths shared by the inertial disagreement monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package imudf_pkg;

  localparam int AXES      = 3;
  localparam int SAMPLE_W  = 16;
  localparam int THRESH_W  = 17;
  localparam int WINDOW_W  = 16;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int SUM_W     = 2 * THRESH_W;
  localparam int KIND_W    = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ACCEL_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_GYRO_THRESHOLD  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_TICKS    = 2'd2;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd100;
  localparam logic [WINDOW_W-1:0] TICKS_MAX    = 16'hFFFF;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] vec_t;
  typedef logic [AXES-1:0][SQ_W-1:0]     sq_vec_t;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic agree;
    logic exceeded;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/imudf_in_if.sv
// ----------------------------------------------------------------------------
// imudf_in_if
// Input item channel: valid/ready with one tick, sample or check item.
// ----------------------------------------------------------------------------
`default_nettype none

interface imudf_in_if import imudf_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/imudf_out_if.sv
// ----------------------------------------------------------------------------
// imudf_out_if
// Result channel: valid/ready with one check result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface imudf_out_if import imudf_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/imudf_cfg_if.sv
// ----------------------------------------------------------------------------
// imudf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface imudf_cfg_if import imudf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [THRESH_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> src/imudf_sqdiff.sv
// ----------------------------------------------------------------------------
// imudf_sqdiff
// Per-axis squared difference of two signed three-axis vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module imudf_sqdiff import imudf_pkg::*; (
  input  vec_t    a,
  input  vec_t    b,
  output sq_vec_t sq
);

  logic signed [AXES-1:0][SAMPLE_W:0] diff;
  logic        [AXES-1:0][SAMPLE_W:0] mag;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i] = $signed({a[i][SAMPLE_W-1], a[i]}) - $signed({b[i][SAMPLE_W-1], b[i]});
      mag[i]  = diff[i][SAMPLE_W] ? (~diff[i] + 1'b1) : diff[i];
      sq[i]   = mag[i][SAMPLE_W-1:0] * mag[i][SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/imu_disagreement_fault_monitor_core.sv
// ----------------------------------------------------------------------------
// imu_disagreement_fault_monitor_core
// Compares reference accel/gyro vectors against the last device sample and
// latches a fault when disagreement outlasts the tick window.
// ----------------------------------------------------------------------------
//  channel | modport | payload                         | beats
//  item    | sink    | kind, accel_x..z, gyro_x..z     | tick, sample or check
//  result  | source  | agree, exceeded                 | one per check
//  cfg     | sink    | index, wdata                    | register write
//
//  One item per cycle unless stalled; each check item yields one result.
//  Stage A squares the differences, stage B sums, compares and updates the
//  persistence timer, then the result register holds the beat.
//  Stalls only when a check in stage B meets a held, untaken result.
//  rst is synchronous; clears control state, vectors, thresholds; window = 100.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_disagreement_fault_monitor_core import imudf_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  imudf_in_if.sink    item,
  imudf_out_if.source result,
  imudf_cfg_if.sink   cfg
);

  logic [THRESH_W-1:0] accel_threshold;
  logic [THRESH_W-1:0] gyro_threshold;
  logic [WINDOW_W-1:0] window_ticks;

  vec_t stored_accel;
  vec_t stored_gyro;
  logic timer_armed;
  logic fault_latched;
  logic [WINDOW_W-1:0] elapsed_ticks;

  logic              a_valid;
  logic [KIND_W-1:0] a_kind;
  vec_t              a_accel;
  vec_t              a_gyro;

  logic              b_valid;
  logic [KIND_W-1:0] b_kind;
  sq_vec_t           b_accel_sq;
  sq_vec_t           b_gyro_sq;
  logic [SUM_W-1:0]  b_accel_lim;
  logic [SUM_W-1:0]  b_gyro_lim;

  logic      out_valid;
  out_item_t out_data;

  sq_vec_t accel_sq;
  sq_vec_t gyro_sq;

  logic out_free, b_go, b_free, a_go, a_free;
  logic [SUM_W-1:0] accel_sum, gyro_sum;
  logic exc;
  logic timer_armed_next, fault_latched_next;
  logic [WINDOW_W-1:0] elapsed_ticks_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_threshold <= '0;
      gyro_threshold  <= '0;
      window_ticks    <= WINDOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ACCEL_THRESHOLD: accel_threshold <= cfg.wdata;
        REG_GYRO_THRESHOLD:  gyro_threshold  <= cfg.wdata;
        REG_WINDOW_TICKS:    window_ticks    <= cfg.wdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid || result.ready;
  assign b_go       = b_valid && ((b_kind != KIND_CHECK) || out_free);
  assign b_free     = !b_valid || b_go;
  assign a_go       = a_valid && b_free;
  assign a_free     = !a_valid || a_go;
  assign item.ready = a_free;

  // stage A: hold the item
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && item.valid) begin
      a_kind  <= item.data.kind;
      a_accel <= {item.data.accel_z, item.data.accel_y, item.data.accel_x};
      a_gyro  <= {item.data.gyro_z, item.data.gyro_y, item.data.gyro_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_accel <= '0;
      stored_gyro  <= '0;
    end else if (a_go && a_kind == KIND_SAMPLE) begin
      stored_accel <= a_accel;
      stored_gyro  <= a_gyro;
    end
  end

  imudf_sqdiff u_accel_sq (.a(a_accel), .b(stored_accel), .sq(accel_sq));
  imudf_sqdiff u_gyro_sq  (.a(a_gyro),  .b(stored_gyro),  .sq(gyro_sq));

  // stage B: squared terms and limits
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_kind      <= a_kind;
      b_accel_sq  <= accel_sq;
      b_gyro_sq   <= gyro_sq;
      b_accel_lim <= accel_threshold * accel_threshold;
      b_gyro_lim  <= gyro_threshold * gyro_threshold;
    end
  end

  assign accel_sum = SUM_W'(b_accel_sq[0]) + SUM_W'(b_accel_sq[1]) + SUM_W'(b_accel_sq[2]);
  assign gyro_sum  = SUM_W'(b_gyro_sq[0]) + SUM_W'(b_gyro_sq[1]) + SUM_W'(b_gyro_sq[2]);
  assign exc       = (accel_sum > b_accel_lim) || (gyro_sum > b_gyro_lim);

  always_comb begin
    timer_armed_next   = timer_armed;
    fault_latched_next = fault_latched;
    elapsed_ticks_next = elapsed_ticks;
    case (b_kind)
      KIND_TICK: begin
        if (timer_armed && elapsed_ticks != TICKS_MAX) begin
          elapsed_ticks_next = elapsed_ticks + 1'b1;
        end
      end
      KIND_CHECK: begin
        if (exc) begin
          if (!timer_armed) begin
            timer_armed_next   = 1'b1;
            elapsed_ticks_next = '0;
          end else if (elapsed_ticks >= window_ticks) begin
            fault_latched_next = 1'b1;
          end
        end else begin
          timer_armed_next   = 1'b0;
          fault_latched_next = 1'b0;
          elapsed_ticks_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_armed   <= 1'b0;
      fault_latched <= 1'b0;
      elapsed_ticks <= '0;
    end else if (b_go) begin
      timer_armed   <= timer_armed_next;
      fault_latched <= fault_latched_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_go && b_kind == KIND_CHECK) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_kind == KIND_CHECK) begin
      out_data.agree    <= !fault_latched_next;
      out_data.exceeded <= exc;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  a_fault_needs_timer: assert property (@(posedge clk) disable iff (rst)
    fault_latched |-> timer_armed)
    else $error("fault latched with timer disarmed");

  a_ticks_need_timer: assert property (@(posedge clk) disable iff (rst)
    (elapsed_ticks != '0) |-> timer_armed)
    else $error("tick count held with timer disarmed");

  a_stall_from_result: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (result.valid && !result.ready))
    else $error("input stalled without a held result");

  a_fault_on_check: assert property (@(posedge clk) disable iff (rst)
    $rose(fault_latched) |-> $past(b_go && b_kind == KIND_CHECK))
    else $error("fault raised outside a check");
`endif

endmodule

`default_nettype wire
